// File: rtl/bps_pkg.sv
// ============================================================================
// bps_pkg
// shared types, widths and constants of the blinn-phong fragment shader
// ============================================================================
package bps_pkg;

    // fixed point
    localparam int FRAC_W    = 14;
    localparam int CH_W      = 16;
    localparam int RGB_W     = 3 * CH_W;
    localparam int Q14_ONE   = 16384;
    localparam int Q14_HALF  = 8192;
    localparam int CFG_W     = 48;
    localparam int SHINE_W   = 8;
    localparam int PIX_W     = 12;

    // stripe discard: column mod 10 through a reciprocal multiply
    localparam int STRIPE_PERIOD = 10;
    localparam int STRIPE_KEEP   = 4;
    localparam int RECIP10       = 6554;
    localparam int RECIP_W       = 13;
    localparam int RECIP_SHIFT   = 16;
    localparam int QUO10_W       = 9;

    // vector normalizer
    localparam int VIN_W      = 17;
    localparam int MAG_W      = VIN_W;
    localparam int SUM_W      = 2 * VIN_W;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int SQ_REM_W   = ROOT_W + 3;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int Q_W        = FRAC_W + 1;
    localparam int DIV_STEPS  = Q_W;
    localparam int DREM_W     = ROOT_W + 1;
    localparam int NORM_LAT   = 4 + SQRT_STEPS + DIV_STEPS;

    // power unit, one exponent bit per stage
    localparam int POW_STEPS  = SHINE_W;

    // input to output latency in cycles
    localparam int TOTAL_LAT  = 2 * NORM_LAT + POW_STEPS + 6;

    typedef logic [2:0][VIN_W-1:0] vin_t;
    typedef logic [2:0][CH_W-1:0]  vq_t;

    typedef enum logic [2:0] {
        REG_LIGHT_POS   = 3'd0,
        REG_CAMERA_POS  = 3'd1,
        REG_AMBIENT     = 3'd2,
        REG_DIFFUSE_LT  = 3'd3,
        REG_SPECULAR_LT = 3'd4,
        REG_SURFACE     = 3'd5,
        REG_SHININESS   = 3'd6,
        REG_SHADE_MODE  = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_STRIPE  = 2'd0,
        MODE_NDC     = 2'd1,
        MODE_LIT     = 2'd2,
        MODE_LIT_TEX = 2'd3
    } shade_mode_t;

    typedef struct packed {
        logic signed [CH_W-1:0] normal_x;
        logic signed [CH_W-1:0] normal_y;
        logic signed [CH_W-1:0] normal_z;
        logic signed [CH_W-1:0] world_x;
        logic signed [CH_W-1:0] world_y;
        logic signed [CH_W-1:0] world_z;
        logic [RGB_W-1:0]       diffuse_texel;
        logic [RGB_W-1:0]       specular_texel;
        logic [RGB_W-1:0]       ndc_position;
        logic [PIX_W-1:0]       pixel_x;
    } frag_t;

    typedef struct packed {
        logic [RGB_W-1:0] color_rgb;
        logic [CH_W-1:0]  color_alpha;
        logic             discarded;
    } result_t;

endpackage

// File: rtl/blinn_phong_fragment_shade_core.sv
// ============================================================================
// blinn_phong_fragment_shade_core
// fixed-point blinn-phong fragment shader with stripe, ndc and lit modes
// ============================================================================
//
//  channel   ports                          dir  meaning
//  --------  -----------------------------  ---  ------------------------------
//  request   start, frag; busy (out)        in   one fragment per start pulse
//  result    done, result                   out  one shaded color per request
//  config    cfg_we, cfg_index, cfg_data    in   register write, no read-back
//
//  - a request is taken on every clock edge with start high; busy stays low
//  - each request passes through two chained normalizers of 36 stages each
//    (normal/light/view then half vector), 2 dot stages, 8 power stages
//    and 4 color stages; results leave in request order
//  - done is high for one cycle with the result; the receiver cannot stall
//  - rst_n clears the valid line and the configuration registers to their reset values
//  - write registers only while no request is in flight; the block does not enforce it
//
module blinn_phong_fragment_shade_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bps_pkg::frag_t              frag,
    output logic                        done,
    output bps_pkg::result_t            result,
    input  logic                        cfg_we,
    input  bps_pkg::cfg_index_t         cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]   cfg_data
);
    import bps_pkg::*;

    localparam int OUT_IDX = TOTAL_LAT - 2;
    localparam int TEX_IDX = TOTAL_LAT - 4;
    localparam int DOT_W   = 32;
    localparam int P_W     = CH_W + 2;
    localparam int C_W     = CH_W + 4;

    // fields that ride along with the request until they are needed
    typedef struct packed {
        logic [RGB_W-1:0] diffuse_texel;
        logic [RGB_W-1:0] specular_texel;
        logic [RGB_W-1:0] ndc_position;
        logic             stripe_cut;
    } side_t;

    typedef struct packed {
        vq_t n;
        vq_t l;
    } nl_t;

    // configuration registers
    logic [CFG_W-1:0]   light_pos_reg;
    logic [CFG_W-1:0]   camera_pos_reg;
    logic [CFG_W-1:0]   ambient_reg;
    logic [CFG_W-1:0]   diffuse_lt_reg;
    logic [CFG_W-1:0]   specular_lt_reg;
    logic [CFG_W-1:0]   surface_reg;
    logic [SHINE_W-1:0] shininess_reg;
    shade_mode_t        shade_mode_reg;

    logic accept;

    // entry
    logic [2:0][CH_W-1:0]        world;
    vin_t                        n_in;
    vin_t                        l_in;
    vin_t                        v_in;
    logic [PIX_W+RECIP_W-1:0]    stripe_prod;
    logic [QUO10_W-1:0]          stripe_quo;
    logic [PIX_W-1:0]            stripe_rem;
    side_t                       side_in;

    // pipeline lines
    logic [TOTAL_LAT-2:0] vld_reg;
    side_t                side_reg [TOTAL_LAT-1];
    nl_t                  nl_dly_reg [NORM_LAT];
    logic [Q_W-1:0]       d_dly_reg [POW_STEPS];

    // normalizer outputs
    vq_t  n_unit;
    vq_t  l_unit;
    vq_t  v_unit;
    vq_t  h_unit;
    vin_t h_in;

    // dot products
    logic signed [2:0][DOT_W-1:0] nl_prod_reg;
    logic signed [2:0][DOT_W-1:0] nh_prod_reg;
    logic [Q_W-1:0]               diff_reg;
    logic [Q_W-1:0]               nh_reg;
    logic [Q_W-1:0]               spec_pow;

    // color stages
    logic [2:0][CH_W-1:0] dif_reg;
    logic [2:0][CH_W-1:0] spc_reg;
    logic [2:0][P_W-1:0]  p_amb_reg;
    logic [2:0][P_W-1:0]  p_dif_reg;
    logic [2:0][P_W-1:0]  p_spc_reg;
    logic [2:0][P_W-1:0]  light_sum_reg;
    logic [2:0][C_W-1:0]  color_reg;

    logic    done_reg;
    result_t result_reg;
    result_t result_next;

    function automatic logic [Q_W-1:0] dot_clamp(input logic signed [DOT_W-1:0] s);
        logic [DOT_W-FRAC_W-1:0] d;
        d = s[DOT_W-1:FRAC_W];
        if (s <= 0)
        begin
            return '0;
        end
        else if (d > (DOT_W-FRAC_W)'(Q14_ONE))
        begin
            return Q_W'(Q14_ONE);
        end
        else
        begin
            return d[Q_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_pos_reg   <= '0;
            camera_pos_reg  <= '0;
            ambient_reg     <= '0;
            diffuse_lt_reg  <= '0;
            specular_lt_reg <= '0;
            surface_reg     <= '0;
            shininess_reg   <= SHINE_W'(32);
            shade_mode_reg  <= MODE_LIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LIGHT_POS:   light_pos_reg   <= cfg_data;
                REG_CAMERA_POS:  camera_pos_reg  <= cfg_data;
                REG_AMBIENT:     ambient_reg     <= cfg_data;
                REG_DIFFUSE_LT:  diffuse_lt_reg  <= cfg_data;
                REG_SPECULAR_LT: specular_lt_reg <= cfg_data;
                REG_SURFACE:     surface_reg     <= cfg_data;
                REG_SHININESS:   shininess_reg   <= cfg_data[SHINE_W-1:0];
                REG_SHADE_MODE:  shade_mode_reg  <= shade_mode_t'(cfg_data[1:0]);
                default:         shade_mode_reg  <= shade_mode_reg;
            endcase
        end
    end

    // fully pipelined, never refuses a request
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // entry: raw vectors, stripe test
    // ------------------------------------------------------------------
    assign world = {frag.world_z, frag.world_y, frag.world_x};

    always_comb
    begin
        n_in[0] = {frag.normal_x[CH_W-1], frag.normal_x};
        n_in[1] = {frag.normal_y[CH_W-1], frag.normal_y};
        n_in[2] = {frag.normal_z[CH_W-1], frag.normal_z};
        for (int k = 0; k < 3; k++)
        begin
            // light and view vectors from the fragment position
            l_in[k] = {light_pos_reg[CH_W*k+CH_W-1], light_pos_reg[CH_W*k +: CH_W]}
                    - {world[k][CH_W-1], world[k]};
            v_in[k] = {camera_pos_reg[CH_W*k+CH_W-1], camera_pos_reg[CH_W*k +: CH_W]}
                    - {world[k][CH_W-1], world[k]};
        end
    end

    // column mod 10 via reciprocal multiply, exact over the 12-bit range
    assign stripe_prod = (PIX_W+RECIP_W)'(frag.pixel_x) * (PIX_W+RECIP_W)'(RECIP10);
    assign stripe_quo  = stripe_prod[RECIP_SHIFT +: QUO10_W];
    assign stripe_rem  = frag.pixel_x - PIX_W'(stripe_quo * STRIPE_PERIOD);

    assign side_in.diffuse_texel  = frag.diffuse_texel;
    assign side_in.specular_texel = frag.specular_texel;
    assign side_in.ndc_position   = frag.ndc_position;
    assign side_in.stripe_cut     = stripe_rem > PIX_W'(STRIPE_KEEP);

    // valid line, one bit per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[TOTAL_LAT-3:0], accept};
            done_reg <= vld_reg[TOTAL_LAT-2];
        end
    end

    // side data follows the valid line
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int i = 1; i < TOTAL_LAT - 1; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // normalize n, l, v side by side, then h = normalize(l + v)
    // ------------------------------------------------------------------
    bps_norm u_norm_n (.clk(clk), .vec(n_in), .unit_vec(n_unit));
    bps_norm u_norm_l (.clk(clk), .vec(l_in), .unit_vec(l_unit));
    bps_norm u_norm_v (.clk(clk), .vec(v_in), .unit_vec(v_unit));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            h_in[k] = {l_unit[k][CH_W-1], l_unit[k]} + {v_unit[k][CH_W-1], v_unit[k]};
        end
    end

    bps_norm u_norm_h (.clk(clk), .vec(h_in), .unit_vec(h_unit));

    // n and l wait for the half vector
    always_ff @(posedge clk)
    begin
        nl_dly_reg[0] <= '{n: n_unit, l: l_unit};
        for (int i = 1; i < NORM_LAT; i++)
        begin
            nl_dly_reg[i] <= nl_dly_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // dot products: products, then sum and clamp
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            nl_prod_reg[k] <= $signed(nl_dly_reg[NORM_LAT-1].n[k])
                            * $signed(nl_dly_reg[NORM_LAT-1].l[k]);
            nh_prod_reg[k] <= $signed(nl_dly_reg[NORM_LAT-1].n[k]) * $signed(h_unit[k]);
        end
        diff_reg <= dot_clamp(nl_prod_reg[0] + nl_prod_reg[1] + nl_prod_reg[2]);
        nh_reg   <= dot_clamp(nh_prod_reg[0] + nh_prod_reg[1] + nh_prod_reg[2]);
    end

    // specular falloff, diffuse term waits alongside
    bps_pow u_pow (
        .clk   (clk),
        .base  (nh_reg),
        .expo  (shininess_reg),
        .power (spec_pow)
    );

    always_ff @(posedge clk)
    begin
        d_dly_reg[0] <= diff_reg;
        for (int i = 1; i < POW_STEPS; i++)
        begin
            d_dly_reg[i] <= d_dly_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // color: light scaling, material products, combine, saturate
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        logic [2*CH_W-1:0]  prod_a;
        logic [2*CH_W-1:0]  prod_b;
        logic [2*CH_W-1:0]  prod_c;
        logic [P_W+CH_W-1:0] prod_lit;
        logic [CH_W-1:0]    amb;
        logic [CH_W-1:0]    dt;
        logic [CH_W-1:0]    st;
        for (int k = 0; k < 3; k++)
        begin
            // light intensities scaled by the two factors
            prod_a     = CH_W'(d_dly_reg[POW_STEPS-1]) * diffuse_lt_reg[CH_W*k +: CH_W];
            prod_b     = CH_W'(spec_pow) * specular_lt_reg[CH_W*k +: CH_W];
            dif_reg[k] <= prod_a[FRAC_W +: CH_W];
            spc_reg[k] <= prod_b[FRAC_W +: CH_W];

            // textured products and untextured light sum
            amb = ambient_reg[CH_W*k +: CH_W];
            dt  = side_reg[TEX_IDX].diffuse_texel[CH_W*k +: CH_W];
            st  = side_reg[TEX_IDX].specular_texel[CH_W*k +: CH_W];
            prod_a = amb * dt;
            prod_b = dif_reg[k] * dt;
            prod_c = spc_reg[k] * st;
            p_amb_reg[k]     <= prod_a[FRAC_W +: P_W];
            p_dif_reg[k]     <= prod_b[FRAC_W +: P_W];
            p_spc_reg[k]     <= prod_c[FRAC_W +: P_W];
            light_sum_reg[k] <= P_W'(amb) + P_W'(dif_reg[k]) + P_W'(spc_reg[k]);

            // final per-channel color before saturation
            prod_lit = light_sum_reg[k] * surface_reg[CH_W*k +: CH_W];
            if (shade_mode_reg == MODE_LIT_TEX)
            begin
                color_reg[k] <= C_W'(p_amb_reg[k]) + C_W'(p_dif_reg[k]) + C_W'(p_spc_reg[k]);
            end
            else
            begin
                color_reg[k] <= prod_lit[FRAC_W +: C_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // output select by mode
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [CH_W:0] ndc_v;
        logic [CH_W-1:0]      ndc_c;
        ndc_v       = '0;
        ndc_c       = '0;
        result_next = '0;
        unique case (shade_mode_reg)
            MODE_STRIPE:
            begin
                if (side_reg[OUT_IDX].stripe_cut)
                begin
                    result_next.discarded = 1'b1;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        result_next.color_rgb[CH_W*k +: CH_W] = CH_W'(Q14_ONE);
                    end
                    result_next.color_alpha = CH_W'(Q14_HALF);
                end
            end
            MODE_NDC:
            begin
                // (c + 1.0) / 2, negative sums clip to zero
                for (int k = 0; k < 3; k++)
                begin
                    ndc_c = side_reg[OUT_IDX].ndc_position[CH_W*k +: CH_W];
                    ndc_v = $signed({ndc_c[CH_W-1], ndc_c}) + $signed((CH_W+1)'(Q14_ONE));
                    result_next.color_rgb[CH_W*k +: CH_W] = ndc_v[CH_W] ? '0 : ndc_v[CH_W:1];
                end
                result_next.color_alpha = CH_W'(Q14_ONE);
            end
            MODE_LIT, MODE_LIT_TEX:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    result_next.color_rgb[CH_W*k +: CH_W] =
                        (color_reg[k][C_W-1:CH_W] != '0) ? '1 : color_reg[k][CH_W-1:0];
                end
                result_next.color_alpha = CH_W'(Q14_ONE);
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_done_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result without a matching request");

    a_request_gets_result: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##TOTAL_LAT done)
        else $error("request lost in the pipeline");

    a_discard_is_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.discarded) |->
            (result.color_rgb == '0 && result.color_alpha == '0))
        else $error("discarded fragment carries color");

    a_lit_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (shade_mode_reg == MODE_LIT || shade_mode_reg == MODE_LIT_TEX)) |->
            (result.color_alpha == CH_W'(Q14_ONE) && !result.discarded))
        else $error("lit fragment not opaque");

endmodule

// File: rtl/bps_norm.sv
// ============================================================================
// bps_norm
// pipelined 3-vector normalizer: squares, integer square root one bit per
// stage, then per-component restoring divide one quotient bit per stage
// ============================================================================
module bps_norm (
    input  logic          clk,
    input  bps_pkg::vin_t vec,
    output bps_pkg::vq_t  unit_vec
);
    import bps_pkg::*;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } comp_t;

    typedef struct packed {
        logic [ROOT_W-1:0]      len;
        logic [2:0]             neg;
        logic [2:0][DREM_W-1:0] rem;
        logic [2:0][Q_W-1:0]    quo;
    } div_t;

    vin_t                  v_reg;
    logic [2:0][SUM_W-1:0] sq_reg;
    logic [2:0][SUM_W-1:0] sq_next;
    comp_t                 sq_comp_reg;
    comp_t                 sq_comp_next;

    logic [SUM_W-1:0]    rad_reg   [SQRT_STEPS+1];
    logic [SQ_REM_W-1:0] srem_reg  [SQRT_STEPS+1];
    logic [ROOT_W-1:0]   root_reg  [SQRT_STEPS+1];
    comp_t               scomp_reg [SQRT_STEPS+1];

    div_t div_reg [DIV_STEPS];
    vq_t  unit_reg;
    vq_t  unit_next;

    // squares and magnitudes
    always_comb
    begin
        logic signed [SUM_W-1:0] sv;
        sv = '0;
        for (int k = 0; k < 3; k++)
        begin
            sv = SUM_W'($signed(v_reg[k]));
            sq_next[k] = sv * sv;
            sq_comp_next.neg[k] = v_reg[k][VIN_W-1];
            sq_comp_next.mag[k] = v_reg[k][VIN_W-1] ? MAG_W'(-v_reg[k]) : MAG_W'(v_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= vec;
        sq_reg       <= sq_next;
        sq_comp_reg  <= sq_comp_next;
        rad_reg[0]   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        srem_reg[0]  <= '0;
        root_reg[0]  <= '0;
        scomp_reg[0] <= sq_comp_reg;
    end

    // square root, two radicand bits per stage
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [SQ_REM_W-1:0] rem_shift;
        logic [SQ_REM_W-1:0] trial;
        logic                fits;

        assign rem_shift = {srem_reg[j][SQ_REM_W-3:0], rad_reg[j][SUM_W-1 -: 2]};
        assign trial     = SQ_REM_W'({root_reg[j], 2'b01});
        assign fits      = rem_shift >= trial;

        always_ff @(posedge clk)
        begin
            rad_reg[j+1]   <= rad_reg[j] << 2;
            srem_reg[j+1]  <= fits ? rem_shift - trial : rem_shift;
            root_reg[j+1]  <= {root_reg[j][ROOT_W-2:0], fits};
            scomp_reg[j+1] <= scomp_reg[j];
        end
    end

    // (mag << 14) / len, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        div_t src;
        div_t nxt;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                src.len = root_reg[SQRT_STEPS];
                src.neg = scomp_reg[SQRT_STEPS].neg;
                src.quo = '0;
                for (int k = 0; k < 3; k++)
                begin
                    src.rem[k] = DREM_W'(scomp_reg[SQRT_STEPS].mag[k]);
                end
            end
        end
        else
        begin : g_rest
            assign src = div_reg[j-1];
        end

        always_comb
        begin
            logic              ge;
            logic [DREM_W-1:0] diff;
            ge   = 1'b0;
            diff = '0;
            nxt  = src;
            for (int k = 0; k < 3; k++)
            begin
                ge   = src.rem[k] >= DREM_W'(src.len);
                diff = ge ? src.rem[k] - DREM_W'(src.len) : src.rem[k];
                nxt.rem[k] = {diff[DREM_W-2:0], 1'b0};
                nxt.quo[k] = {src.quo[k][Q_W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[j] <= nxt;
        end
    end

    // sign back on, zero vector gives zero
    always_comb
    begin
        logic [CH_W-1:0] q16;
        q16 = '0;
        for (int k = 0; k < 3; k++)
        begin
            q16 = CH_W'(div_reg[DIV_STEPS-1].quo[k]);
            if (div_reg[DIV_STEPS-1].len == '0)
            begin
                unit_next[k] = '0;
            end
            else
            begin
                unit_next[k] = div_reg[DIV_STEPS-1].neg[k] ? -q16 : q16;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
    end

    assign unit_vec = unit_reg;

endmodule

// File: rtl/bps_pow.sv
// ============================================================================
// bps_pow
// q1.14 power by square-and-multiply, one exponent bit per pipeline stage
// ============================================================================
module bps_pow (
    input  logic                         clk,
    input  logic [bps_pkg::Q_W-1:0]      base,
    input  logic [bps_pkg::SHINE_W-1:0]  expo,
    output logic [bps_pkg::Q_W-1:0]      power
);
    import bps_pkg::*;

    logic [Q_W-1:0] acc_reg [POW_STEPS];
    logic [Q_W-1:0] sq_reg  [POW_STEPS];

    for (genvar j = 0; j < POW_STEPS; j++)
    begin : g_step
        logic [Q_W-1:0]   acc_src;
        logic [Q_W-1:0]   sq_src;
        logic [2*Q_W-1:0] acc_prod;
        logic [2*Q_W-1:0] sq_prod;

        if (j == 0)
        begin : g_first
            assign acc_src = Q_W'(Q14_ONE);
            assign sq_src  = base;
        end
        else
        begin : g_rest
            assign acc_src = acc_reg[j-1];
            assign sq_src  = sq_reg[j-1];
        end

        assign acc_prod = acc_src * sq_src;
        assign sq_prod  = sq_src * sq_src;

        always_ff @(posedge clk)
        begin
            acc_reg[j] <= expo[j] ? acc_prod[FRAC_W +: Q_W] : acc_src;
            sq_reg[j]  <= sq_prod[FRAC_W +: Q_W];
        end
    end

    assign power = acc_reg[POW_STEPS-1];

endmodule
